### sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and the CRC-16 table function for the serial
// frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CrcW-1:0]  CrcPoly        = 16'h8005;
  localparam logic [LenW-1:0]  MinLen         = 16'd7;
  localparam logic [ByteW-1:0] MarkerReset    = 8'd83;
  localparam logic [LenW-1:0]  MaxLenReset    = 16'd128;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxLen      = 1'd1;

  typedef enum logic [KindW-1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_CRC = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_e;

  // MSB-first remainder of (idx << 8) under the 0x8005 polynomial
  function automatic logic [CrcW-1:0] crc_table(input logic [ByteW-1:0] idx);
    logic [CrcW-1:0] c;
    c = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      else           c = {c[CrcW-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    return {8'h00, crc[CrcW-1:8]} ^ crc_table(crc[ByteW-1:0] ^ b);
  endfunction

endpackage

### sv/serial_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_crc16
// Hunts for a start marker, parses address, length, command, data and a
// little-endian CRC-16 trailer; emits data bytes and a frame status.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, byte_in_i         | sink
//  out     | out_valid_o, out_ready_i, kind_o, data_byte_o, address_o,
//          | command_o, frame_length_o, received_crc_o | source
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | sink
//
// One byte per cycle while the input is ready: each accepted byte passes the
// parser (and, for address to data bytes, one CRC table step) in the accept cycle,
// and any result it produces lands in the output register at the accepting edge, so it is valid from the next cycle.
// The input stays ready while the output register is empty or being drained.
// Reset returns the parser to hunting and the control and configuration registers to their defaults.
// Configuration writes are always accepted and take effect at once.
// ----------------------------------------------------------------------------
module serial_frame_deframer_crc16 import sfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    byte_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KindW-1:0]    kind_o,
  output logic [ByteW-1:0]    data_byte_o,
  output logic [ByteW-1:0]    address_o,
  output logic [ByteW-1:0]    command_o,
  output logic [LenW-1:0]     frame_length_o,
  output logic [CrcW-1:0]     received_crc_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhAddr  = 3'd1;
  localparam logic [2:0] PhLenLo = 3'd2;
  localparam logic [2:0] PhLenHi = 3'd3;
  localparam logic [2:0] PhCmd   = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhCrcLo = 3'd6;
  localparam logic [2:0] PhCrcHi = 3'd7;

  logic [ByteW-1:0] marker_q;
  logic [LenW-1:0]  max_len_q;

  logic [2:0]       phase_q, phase_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  data_left_q, data_left_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] crc_lo_q, crc_lo_d;

  logic             out_valid_q;
  logic [KindW-1:0] kind_q, kind_d;
  logic [ByteW-1:0] data_q, data_d;
  logic [ByteW-1:0] oaddr_q;
  logic [ByteW-1:0] ocmd_q, ocmd_d;
  logic [LenW-1:0]  olen_q;
  logic [CrcW-1:0]  orcrc_q, orcrc_d;
  logic             emit_d;

  logic             in_acc;
  logic [LenW-1:0]  full_len;
  logic [CrcW-1:0]  crc_next;
  logic [CrcW-1:0]  rx_crc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign crc_next = crc_update(crc_q, byte_in_i);
  assign full_len = {byte_in_i, len_q[ByteW-1:0]};
  assign rx_crc   = {byte_in_i, crc_lo_q};

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    data_left_d = data_left_q;
    crc_d       = crc_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    crc_lo_d    = crc_lo_q;
    emit_d      = 1'b0;
    kind_d      = KIND_DATA;
    data_d      = '0;
    ocmd_d      = cmd_q;
    orcrc_d     = '0;
    unique case (phase_q)
      PhHunt: begin
        if (byte_in_i == marker_q) begin
          crc_d    = '0;
          len_d    = '0;
          addr_d   = '0;
          cmd_d    = '0;
          crc_lo_d = '0;
          phase_d  = PhAddr;
        end
      end
      PhAddr: begin
        addr_d  = byte_in_i;
        crc_d   = crc_next;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {{(LenW-ByteW){1'b0}}, byte_in_i};
        crc_d   = crc_next;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d       = full_len;
        crc_d       = crc_next;
        data_left_d = full_len - MinLen;
        if (full_len < MinLen || full_len > max_len_q) begin
          phase_d = PhHunt;
          emit_d  = 1'b1;
          kind_d  = KIND_BAD_LEN;
          ocmd_d  = '0;
        end else begin
          phase_d = PhCmd;
        end
      end
      PhCmd: begin
        cmd_d   = byte_in_i;
        crc_d   = crc_next;
        phase_d = (len_q > MinLen) ? PhData : PhCrcLo;
      end
      PhData: begin
        crc_d       = crc_next;
        data_left_d = data_left_q - LenW'(1);
        if (data_left_q == 16'd1) phase_d = PhCrcLo;
        emit_d = 1'b1;
        kind_d = KIND_DATA;
        data_d = byte_in_i;
      end
      PhCrcLo: begin
        crc_lo_d = byte_in_i;
        phase_d  = PhCrcHi;
      end
      PhCrcHi: begin
        phase_d = PhHunt;
        emit_d  = 1'b1;
        kind_d  = (rx_crc == crc_q) ? KIND_GOOD : KIND_BAD_CRC;
        orcrc_d = rx_crc;
      end
      default: phase_d = PhHunt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q  <= MarkerReset;
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStartMarker: marker_q  <= cfg_data_i[ByteW-1:0];
        CfgMaxLen:      max_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      len_q       <= '0;
      data_left_q <= '0;
      crc_q       <= '0;
      addr_q      <= '0;
      cmd_q       <= '0;
      crc_lo_q    <= '0;
    end else if (in_acc) begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      data_left_q <= data_left_d;
      crc_q       <= crc_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      crc_lo_q    <= crc_lo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_acc && emit_d;
    end
  end

  // result payload, loaded only when an item produces a result
  always_ff @(posedge clk_i) begin
    if (in_acc && emit_d) begin
      kind_q  <= kind_d;
      data_q  <= data_d;
      oaddr_q <= addr_q;
      ocmd_q  <= ocmd_d;
      olen_q  <= len_d;
      orcrc_q <= orcrc_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign address_o      = oaddr_q;
  assign command_o      = ocmd_q;
  assign frame_length_o = olen_q;
  assign received_crc_o = orcrc_q;

endmodule

### sv/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [KindW-1:0]   kind_o,
  input logic [ByteW-1:0]   data_byte_o,
  input logic [ByteW-1:0]   command_o,
  input logic [LenW-1:0]    frame_length_o,
  input logic [CrcW-1:0]    received_crc_o
);

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(data_byte_o) && $stable(received_crc_o))
    else $error("stalled result item changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DATA |-> data_byte_o == '0)
    else $error("status item carries a data byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BAD_LEN |-> command_o == '0 && received_crc_o == '0)
    else $error("bad-length item carries command or crc");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA || kind_o == KIND_GOOD || kind_o == KIND_BAD_CRC)
      |-> frame_length_o >= MinLen)
    else $error("accepted frame with short length");

endmodule

bind serial_frame_deframer_crc16 sfd_checker u_sfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kind_o         (kind_o),
  .data_byte_o    (data_byte_o),
  .command_o      (command_o),
  .frame_length_o (frame_length_o),
  .received_crc_o (received_crc_o)
);
